### rtl/core/smi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smi_pkg: shared types and constants of the servo motion interpolator
// Angle format, command codes, channel store entry, controller states,
// the controller/datapath command and status groups, and the pulse mapping.
// ----------------------------------------------------------------------------
package smi_pkg;

   localparam int SMI_CHANNELS_DEF = 16;
   localparam int SMI_FRAC_BITS    = 6;
   localparam int SMI_AW           = 14;   // angle width, 180 degrees fits
   localparam int SMI_TW           = 32;   // time and duration width
   localparam int SMI_QW           = 14;   // interpolation quotient width
   localparam int SMI_MAX_RESULTS  = 16;
   localparam int SMI_CNT_W        = 5;

   localparam logic [SMI_AW-1:0] SMI_FULL_ANGLE = SMI_AW'(180 << SMI_FRAC_BITS);

   typedef enum logic [1:0] {
      OP_SET_CAL = 2'd0,
      OP_SET_RAW = 2'd1,
      OP_MOVE    = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_EVAL,
      ST_DIV,
      ST_TWRITE
   } state_type;

   typedef struct packed {
      logic [SMI_AW-1:0] cur;
      logic [SMI_AW-1:0] start;
      logic [SMI_AW-1:0] tgt;
      logic [SMI_TW-1:0] t0;
      logic [SMI_TW-1:0] dur;
   } entry_type;

   typedef struct packed {
      logic capture;   // latch the request and read its channel
      logic apply;     // write a set or move request, report it unless a timed move
      logic scan_rd;   // read the channel under the scan index
      logic eval;      // compare elapsed time, form the product
      logic div_step;  // one quotient bit
      logic twrite;    // write back the ticked channel, report it
      logic last;      // final report of this tick
   } ctl_type;

   typedef struct packed {
      logic idx_moving;
      logic more_moving;
      logic tick_done;
   } sts_type;

   // Off count: 102 + (whole degrees * 410) / 180, done as deg*41/18 with a
   // reciprocal multiply that is exact for degrees up to 180.
   function automatic logic [9:0] pulse_of(input logic [SMI_AW-1:0] ang);
      logic [7:0]  deg;
      logic [13:0] x;
      logic [25:0] y;
      deg = 8'(ang >> SMI_FRAC_BITS);
      x   = 14'(deg) * 14'd41;
      y   = 26'(x) * 26'd3641;
      return 10'd102 + 10'(y >> 16);
   endfunction

endpackage
`default_nettype wire

### rtl/core/smi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smi_ctrl: request sequencer
// Decodes each request, walks the channels on a tick and paces the divider.
// ----------------------------------------------------------------------------
module smi_ctrl import smi_pkg::*; #(
   parameter int CHANNELS = SMI_CHANNELS_DEF,
   parameter int IW       = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    req_op,
   input  wire logic [3:0]    req_channel,
   input  wire sts_type       sts,
   output logic               busy,
   output ctl_type            ctl,
   output logic [IW-1:0]      idx
);

   localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

   state_type            state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [SMI_CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]           step_ff, step_in;
   logic                 ch_ok;

   assign ch_ok = ({3'b000, req_channel} < 7'(CHANNELS));
   assign idx   = idx_ff;
   assign busy  = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               idx_in      = '0;
               cnt_in      = '0;
               if (op_type'(req_op) == OP_TICK) begin
                  state_in = ST_SCAN;
               end else if (ch_ok) begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            ctl.apply = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.idx_moving) begin
               ctl.scan_rd = 1'b1;
               state_in    = ST_EVAL;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EVAL: begin
            ctl.eval = 1'b1;
            step_in  = '0;
            state_in = sts.tick_done ? ST_TWRITE : ST_DIV;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == 4'(SMI_QW - 1)) begin
               state_in = ST_TWRITE;
            end
         end
         ST_TWRITE: begin
            ctl.twrite = 1'b1;
            ctl.last   = (cnt_ff == SMI_CNT_W'(SMI_MAX_RESULTS - 1)) || !sts.more_moving;
            cnt_in     = cnt_ff + 1'b1;
            if (ctl.last || idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> state_ff == ST_DIV || state_ff == ST_TWRITE)
      else $error("divider left early");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SMI_CNT_W'(SMI_MAX_RESULTS))
      else $error("report count overran");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> step_ff < 4'(SMI_QW))
      else $error("divider step overran");
`endif

endmodule
`default_nettype wire

### rtl/core/smi_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smi_datapath: channel store, calibration, interpolation and reports
// Holds the channel memory, moving flags, a bit-serial divider and the
// report register.
// ----------------------------------------------------------------------------
module smi_datapath import smi_pkg::*; #(
   parameter int CHANNELS = SMI_CHANNELS_DEF,
   parameter int IW       = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_type             ctl,
   input  wire logic [IW-1:0]       idx,
   input  wire logic [1:0]          req_op,
   input  wire logic [3:0]          req_channel,
   input  wire logic signed [15:0]  req_angle,
   input  wire logic [31:0]         req_duration_ms,
   input  wire logic signed [14:0]  req_offset,
   input  wire logic                req_mirror,
   input  wire logic [13:0]         req_limit_low,
   input  wire logic [13:0]         req_limit_high,
   input  wire logic [31:0]         req_now_ms,
   output sts_type                  sts,
   output logic                     rsp_valid,
   output logic [3:0]               rsp_out_channel,
   output logic [9:0]               rsp_pulse,
   output logic [13:0]              rsp_out_angle,
   output logic                     rsp_last
);

   entry_type         mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff, moving_ff;
   entry_type         rd_ff;
   logic              rd_valid_ff;
   entry_type         ent, wr_data;
   logic              wr_en;
   logic [IW-1:0]     wr_addr, rd_addr;

   op_type            op_ff;
   logic [3:0]        ch_ff;
   logic [SMI_AW-1:0] ang_ff, ang_in;
   logic [SMI_TW-1:0] dur_ff, now_ff;

   logic [SMI_TW-1:0] el;
   logic              neg;
   logic [SMI_AW-1:0] mag, new_cur;
   logic [SMI_TW+SMI_QW-1:0] prod;
   logic [SMI_TW-1:0] rem_ff;
   logic [SMI_QW-1:0] qs_ff;
   logic              neg_ff, done_ff;
   logic [SMI_TW:0]   trial;
   logic              qbit;

   logic              rv_ff, rl_ff;
   logic [3:0]        rc_ff;
   logic [9:0]        rp_ff;
   logic [SMI_AW-1:0] ra_ff;
   logic              emit;
   logic [SMI_AW-1:0] emit_ang;
   logic [3:0]        emit_ch;

   function automatic logic [SMI_AW-1:0] sat_full(input logic signed [17:0] a);
      if (a < 18'sd0) return '0;
      if (a > $signed(18'(SMI_FULL_ANGLE))) return SMI_FULL_ANGLE;
      return SMI_AW'(a);
   endfunction

   // Angle of a set or move request, calibrated or raw.
   always_comb begin
      logic signed [17:0] a;
      logic signed [17:0] lo, hi;
      a  = 18'(req_angle) + 18'(req_offset);
      lo = $signed({4'b0000, req_limit_low});
      hi = $signed({4'b0000, req_limit_high});
      if (req_mirror) a = $signed(18'(SMI_FULL_ANGLE)) - a;
      if (a < lo) a = lo;
      else if (a > hi) a = hi;
      if (op_type'(req_op) == OP_SET_RAW) ang_in = sat_full(18'(req_angle));
      else ang_in = sat_full(a);
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         op_ff  <= op_type'(req_op);
         ch_ff  <= req_channel;
         ang_ff <= ang_in;
         dur_ff <= req_duration_ms;
         now_ff <= req_now_ms;
      end
   end

   // Channel memory, registered read.
   assign rd_addr = ctl.capture ? IW'(req_channel) : idx;
   assign ent     = rd_valid_ff ? rd_ff : '0;

   always_ff @(posedge clock) begin
      if (ctl.capture || ctl.scan_rd) begin
         rd_ff       <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         moving_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.capture || ctl.scan_rd) rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (ctl.apply) moving_ff[wr_addr] <= (op_ff == OP_MOVE) && (dur_ff != '0);
         if (ctl.twrite) moving_ff[wr_addr] <= !done_ff;
      end
   end

   // Tick evaluation and divider.
   assign el    = now_ff - ent.t0;
   assign neg   = ent.tgt < ent.start;
   assign mag   = neg ? ent.start - ent.tgt : ent.tgt - ent.start;
   assign prod  = (SMI_TW+SMI_QW)'(mag) * (SMI_TW+SMI_QW)'(el);
   assign trial = {rem_ff, qs_ff[SMI_QW-1]};
   assign qbit  = trial >= {1'b0, ent.dur};

   always_ff @(posedge clock) begin
      if (ctl.eval) begin
         done_ff <= el >= ent.dur;
         neg_ff  <= neg;
         rem_ff  <= prod[SMI_TW+SMI_QW-1:SMI_QW];
         qs_ff   <= prod[SMI_QW-1:0];
      end else if (ctl.div_step) begin
         rem_ff <= qbit ? SMI_TW'(trial - {1'b0, ent.dur}) : trial[SMI_TW-1:0];
         qs_ff  <= {qs_ff[SMI_QW-2:0], qbit};
      end
   end

   assign new_cur = done_ff ? ent.tgt
                  : (neg_ff ? ent.start - qs_ff : ent.start + qs_ff);

   // Write-back and report selection.
   always_comb begin
      wr_en    = ctl.apply || ctl.twrite;
      wr_addr  = ctl.apply ? IW'(ch_ff) : idx;
      wr_data  = ent;
      emit     = 1'b0;
      emit_ang = new_cur;
      emit_ch  = 4'(idx);
      if (ctl.apply) begin
         emit_ang = ang_ff;
         emit_ch  = ch_ff;
         wr_data.tgt = ang_ff;
         if (op_ff == OP_MOVE) begin
            wr_data.start = ent.cur;
            wr_data.t0    = now_ff;
            wr_data.dur   = dur_ff;
            if (dur_ff == '0) wr_data.cur = ang_ff;
            emit = (dur_ff == '0);
         end else begin
            wr_data.cur = ang_ff;
            emit        = 1'b1;
         end
      end else if (ctl.twrite) begin
         wr_data.cur = new_cur;
         emit        = 1'b1;
      end
   end

   always_comb begin
      sts.idx_moving  = moving_ff[idx];
      sts.tick_done   = el >= ent.dur;
      sts.more_moving = 1'b0;
      for (int j = 0; j < CHANNELS; j++) begin
         if (moving_ff[j] && (j > int'(idx))) sts.more_moving = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= emit;
      end
      if (emit) begin
         rc_ff <= emit_ch;
         rp_ff <= pulse_of(emit_ang);
         ra_ff <= emit_ang;
         rl_ff <= ctl.apply ? 1'b1 : ctl.last;
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_channel = rc_ff;
   assign rsp_pulse       = rp_ff;
   assign rsp_out_angle   = ra_ff;
   assign rsp_last        = rl_ff;

`ifndef ASSERT_OFF
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(ctl.apply || ctl.twrite))
      else $error("report without a write");
   a_moving_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(ctl.apply || ctl.twrite) |-> $stable(moving_ff))
      else $error("moving flags changed without a write");
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_angle <= SMI_FULL_ANGLE)
      else $error("reported angle out of range");
`endif

endmodule
`default_nettype wire

### rtl/core/servo_motion_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_motion_interpolator: multi-channel servo linear motion interpolator
// Keeps a set of servo channels and turns set, move and tick requests into
// per-channel pulse width reports.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low. Set
// requests place a channel at a calibrated or raw angle; a move request
// latches the present angle and starts a linear motion to the target; a tick
// request advances every moving channel in ascending order.
// Each report appears on the rsp_ ports for one cycle with rsp_valid high;
// rsp_last marks the final report of a request. The receiver cannot stall.
// A set, or a move with zero duration, holds busy for the apply state; its
// report sits on the rsp_ ports in the cycle after, the first with busy low
// again. A move with a duration reports nothing and likewise holds busy.
// A tick spends the scan state on each idle channel; scan, evaluate and
// write-back on each channel that reaches its target; and scan, evaluate,
// the divide steps and write-back on each channel still under way, since
// the quotient of the interpolation comes one bit per cycle from a shared
// divider. At most sixteen channels report per tick.
// Reset clears all channels to angle zero and stops all motion; it needs
// no clearing pass, valid flags mark channels never written.
// ----------------------------------------------------------------------------
module servo_motion_interpolator import smi_pkg::*; #(
   parameter int CHANNELS = SMI_CHANNELS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_op,
   input  wire logic [3:0]         req_channel,
   input  wire logic signed [15:0] req_angle,
   input  wire logic [31:0]        req_duration_ms,
   input  wire logic signed [14:0] req_offset,
   input  wire logic               req_mirror,
   input  wire logic [13:0]        req_limit_low,
   input  wire logic [13:0]        req_limit_high,
   input  wire logic [31:0]        req_now_ms,
   output logic                    rsp_valid,
   output logic [3:0]              rsp_out_channel,
   output logic [9:0]              rsp_pulse,
   output logic [13:0]             rsp_out_angle,
   output logic                    rsp_last
);

   // Index width of the channel store.
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   ctl_type       ctl;
   sts_type       sts;
   logic [IW-1:0] idx;

   // The sequencer decides what happens in each cycle.
   smi_ctrl #(
      .CHANNELS (CHANNELS),
      .IW       (IW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_op      (req_op),
      .req_channel (req_channel),
      .sts         (sts),
      .busy        (busy),
      .ctl         (ctl),
      .idx         (idx)
   );

   // The datapath holds the channels and produces the reports.
   smi_datapath #(
      .CHANNELS (CHANNELS),
      .IW       (IW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .idx             (idx),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_angle       (req_angle),
      .req_duration_ms (req_duration_ms),
      .req_offset      (req_offset),
      .req_mirror      (req_mirror),
      .req_limit_low   (req_limit_low),
      .req_limit_high  (req_limit_high),
      .req_now_ms      (req_now_ms),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_out_channel (rsp_out_channel),
      .rsp_pulse       (rsp_pulse),
      .rsp_out_angle   (rsp_out_angle),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
